// ===== src/nfa_word_acceptor_top_macros.svh =====
// Assertion macros shared by the checker of the NFA word acceptor
`ifndef NFA_WORD_ACCEPTOR_TOP_MACROS_SVH
`define NFA_WORD_ACCEPTOR_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define NWA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define NWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nwa_pkg.sv =====
// Shared constants, codes and helpers of the NFA word acceptor
`default_nettype none
package nwa_pkg;

    localparam int NUM_STATES  = 16;
    localparam int STATE_BITS  = $clog2(NUM_STATES);
    localparam int SYMBOL_BITS = 8;
    localparam int SET_W       = NUM_STATES;
    localparam int CNT_W       = $clog2(NUM_STATES + 1);
    localparam int IDX_W       = $clog2(NUM_STATES + 1);
    localparam int TBL_AW      = STATE_BITS + SYMBOL_BITS;
    localparam int TBL_DEPTH   = 1 << TBL_AW;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [SYMBOL_BITS-1:0] LAMBDA_SYM = SYMBOL_BITS'(48);

    // item opcodes
    localparam logic [1:0] OP_ADD_TRANS = 2'd0;
    localparam logic [1:0] OP_START     = 2'd1;
    localparam logic [1:0] OP_SYMBOL    = 2'd2;

    // register indexes
    localparam logic [1:0] REG_INITIAL  = 2'd0;
    localparam logic [1:0] REG_FINAL    = 2'd1;
    localparam logic [1:0] REG_COUNT    = 2'd2;

    // states below the count are in use; counts above NUM_STATES saturate
    function automatic logic [SET_W-1:0] used_mask(input logic [CNT_W-1:0] n);
        logic [SET_W:0] w_one;
        begin
            w_one     = (SET_W + 1)'(1) << n;
            used_mask = SET_W'(w_one - (SET_W + 1)'(1));
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/nwa_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module nwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/nfa_word_acceptor_top.sv =====
// NFA word acceptor: transition table in RAM, bit-set state, lambda closure
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+-------------------------------------
// item in   | input     | start & !busy             | opcode, from_state, symbol, to_state
// result    | output    | o_valid, one cycle        | active_set, accepted, dead
// config    | input     | APB psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// After reset the table is cleared one entry a cycle; busy stays high until all 4096 entries are cleared.
// Load item: the row is read at accept and written back with the target bit in S_LOAD.
// Start item: one or more closure passes in S_CLOSE; symbol item: one scan in S_MOVE,
// then the closure passes; one table read port scans one state per cycle.
// The result strobe comes in the first cycle with busy low; it cannot be held off.
`default_nettype none
module nfa_word_acceptor_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [nwa_pkg::STATE_BITS-1:0]    i_from_state,
    input  wire logic [nwa_pkg::SYMBOL_BITS-1:0]   i_symbol,
    input  wire logic [nwa_pkg::STATE_BITS-1:0]    i_to_state,
    output logic                                   o_valid,
    output logic      [nwa_pkg::SET_W-1:0]         o_active_set,
    output logic                                   o_accepted,
    output logic                                   o_dead,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nwa_pkg::APB_AW-1:0]        paddr,
    input  wire logic [nwa_pkg::APB_DW-1:0]        pwdata,
    output logic      [nwa_pkg::APB_DW-1:0]        prdata,
    output logic                                   pready
);
    import nwa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_MOVE,
        S_CLOSE
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_valid, n_valid;
    logic [SET_W-1:0]        r_out_set, n_out_set;
    logic                    r_accepted, n_accepted;
    logic                    r_dead, n_dead;
    logic [STATE_BITS-1:0]   r_init, n_init;
    logic [SET_W-1:0]        r_final, n_final;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [SET_W-1:0]        r_cur, n_cur;
    logic [TBL_AW-1:0]       r_clr, n_clr;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_rd_vld, n_rd_vld;
    logic [SET_W-1:0]        r_set, n_set;
    logic [SET_W-1:0]        r_acc, n_acc;
    logic                    r_chg, n_chg;
    logic [SYMBOL_BITS-1:0]  r_sym, n_sym;
    logic [STATE_BITS-1:0]   r_from, n_from;
    logic [STATE_BITS-1:0]   r_to, n_to;

    logic                    ram_we;
    logic [TBL_AW-1:0]       ram_waddr;
    logic [SET_W-1:0]        ram_wdata;
    logic [TBL_AW-1:0]       ram_raddr;
    logic [SET_W-1:0]        ram_rdata;

    logic [SET_W-1:0]        w_mask;
    logic [SET_W-1:0]        w_hit;
    logic [SET_W-1:0]        w_new;
    logic                    w_chg;
    logic                    w_take;
    logic                    w_cfg_wr;
    logic [1:0]              w_reg_idx;
    logic [STATE_BITS-1:0]   w_scan_st;
    logic                    w_last;

    nwa_ram #(
        .WIDTH (SET_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_active_set = r_out_set;
    assign o_accepted   = r_accepted;
    assign o_dead       = r_dead;
    assign pready       = 1'b1;

    assign w_take    = start && !busy;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[APB_AW-1:2];
    assign w_mask    = used_mask(r_count);
    // row read in the previous cycle counts only if its state was active
    assign w_hit     = r_rd_vld ? (ram_rdata & w_mask) : '0;
    assign w_new     = r_set | w_hit;
    assign w_chg     = r_chg || (w_new != r_set);
    assign w_scan_st = r_idx[STATE_BITS-1:0];
    assign w_last    = (r_idx == IDX_W'(NUM_STATES));

    always_comb begin
        unique case (w_reg_idx)
            REG_INITIAL: prdata = APB_DW'(r_init);
            REG_FINAL:   prdata = APB_DW'(r_final);
            REG_COUNT:   prdata = APB_DW'(r_count);
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = 1'b0;
        n_out_set  = r_out_set;
        n_accepted = r_accepted;
        n_dead     = r_dead;
        n_init     = r_init;
        n_final    = r_final;
        n_count    = r_count;
        n_cur      = r_cur;
        n_clr      = r_clr;
        n_idx      = r_idx;
        n_rd_vld   = r_rd_vld;
        n_set      = r_set;
        n_acc      = r_acc;
        n_chg      = r_chg;
        n_sym      = r_sym;
        n_from     = r_from;
        n_to       = r_to;
        ram_we     = 1'b0;
        ram_waddr  = r_clr;
        ram_wdata  = '0;
        ram_raddr  = {i_from_state, i_symbol};

        if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_INITIAL: n_init  = pwdata[STATE_BITS-1:0];
                REG_FINAL:   n_final = pwdata[SET_W-1:0];
                REG_COUNT:   n_count = pwdata[CNT_W-1:0];
                default:     ;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + TBL_AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_chg    = 1'b0;
                    case (i_opcode)
                        OP_ADD_TRANS: begin
                            n_from  = i_from_state;
                            n_sym   = i_symbol;
                            n_to    = i_to_state;
                            n_state = S_LOAD;
                        end
                        OP_START: begin
                            n_set   = (SET_W'(1) << r_init) & w_mask;
                            n_state = S_CLOSE;
                        end
                        OP_SYMBOL: begin
                            n_set   = r_cur & w_mask;
                            n_acc   = '0;
                            n_sym   = i_symbol;
                            n_state = S_MOVE;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                // read-modify-write: the row read at accept is on ram_rdata now
                ram_we    = 1'b1;
                ram_waddr = {r_from, r_sym};
                ram_wdata = ram_rdata | (SET_W'(1) << r_to);
                n_state   = S_IDLE;
            end
            S_MOVE: begin
                ram_raddr = {w_scan_st, r_sym};
                n_acc     = r_acc | w_hit;
                if (w_last) begin
                    n_set    = r_acc | w_hit;
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_chg    = 1'b0;
                    n_state  = S_CLOSE;
                end else begin
                    n_rd_vld = r_set[w_scan_st];
                    n_idx    = r_idx + IDX_W'(1);
                end
            end
            S_CLOSE: begin
                // lambda rows merge in place; repeat passes until one adds nothing
                ram_raddr = {w_scan_st, LAMBDA_SYM};
                n_set     = w_new;
                n_chg     = w_chg;
                if (w_last) begin
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_chg    = 1'b0;
                    if (!w_chg) begin
                        n_valid    = 1'b1;
                        n_out_set  = w_new;
                        n_accepted = |(w_new & r_final);
                        n_dead     = (w_new == '0);
                        n_cur      = w_new;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_rd_vld = r_set[w_scan_st];
                    n_idx    = r_idx + IDX_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_set  <= n_out_set;
        r_accepted <= n_accepted;
        r_dead     <= n_dead;
        r_idx      <= n_idx;
        r_rd_vld   <= n_rd_vld;
        r_set      <= n_set;
        r_acc      <= n_acc;
        r_chg      <= n_chg;
        r_sym      <= n_sym;
        r_from     <= n_from;
        r_to       <= n_to;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
            r_init  <= '0;
            r_final <= '0;
            r_count <= CNT_W'(NUM_STATES);
            r_cur   <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_init  <= n_init;
            r_final <= n_final;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_clr   <= n_clr;
        end
    end

endmodule
`default_nettype wire

// ===== src/nwa_chk.sv =====
// Port-level checker of the NFA word acceptor, bound to the top level
`default_nettype none
`include "nfa_word_acceptor_top_macros.svh"
module nwa_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [1:0]                        i_opcode,
    input wire logic                              o_valid,
    input wire logic [nwa_pkg::SET_W-1:0]         o_active_set,
    input wire logic                              o_accepted,
    input wire logic                              o_dead
);
    import nwa_pkg::*;

    logic w_take;

    // accepted item with an opcode that does work
    assign w_take = start && !busy && (i_opcode == OP_ADD_TRANS || i_opcode == OP_START ||
                    i_opcode == OP_SYMBOL);

    `NWA_ASSERT_NOW(a_dead_matches_set, o_valid, o_dead == (o_active_set == '0), "dead flag wrong")
    `NWA_ASSERT_NOW(a_dead_not_accepted, o_valid, !(o_accepted && o_dead), "empty set accepted")
    `NWA_ASSERT_NOW(a_result_when_idle, o_valid, !busy, "result while busy")
    `NWA_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than a cycle")
    `NWA_ASSERT_NEXT(a_item_goes_busy, w_take, busy, "accepted item did not raise busy")

endmodule

bind nfa_word_acceptor_top nwa_chk u_nwa_chk (.*);
`default_nettype wire

// ===== verif/nfa_word_acceptor_checker.sv =====
// Checker for the NFA word acceptor: mirrors table, registers and active set, compares results
`timescale 1ns / 1ps
module nfa_word_acceptor_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      i_opcode,
    input  logic [nwa_pkg::STATE_BITS-1:0]  i_from_state,
    input  logic [nwa_pkg::SYMBOL_BITS-1:0] i_symbol,
    input  logic [nwa_pkg::STATE_BITS-1:0]  i_to_state,
    input  logic                            o_valid,
    input  logic [nwa_pkg::SET_W-1:0]       o_active_set,
    input  logic                            o_accepted,
    input  logic                            o_dead,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nwa_pkg::APB_AW-1:0]      paddr,
    input  logic [nwa_pkg::APB_DW-1:0]      pwdata,
    input  logic                            pready,
    output int                              o_errors,
    output int                              o_pending
);
    import nwa_pkg::*;

    typedef struct packed {
        logic [SET_W-1:0] active_set;
        logic             accepted;
        logic             dead;
    } t_step_result;

    t_step_result          expected_sets[$];
    t_step_result          want;
    logic [SET_W-1:0]      trans_mem [0:TBL_DEPTH-1];
    logic [SET_W-1:0]      act_set;
    logic [STATE_BITS-1:0] init_state;
    logic [SET_W-1:0]      accept_mask;
    logic [CNT_W-1:0]      num_used;
    logic [SET_W-1:0]      in_use;

    // states below the count; counts above NUM_STATES saturate
    function automatic logic [SET_W-1:0] states_in_use(input logic [CNT_W-1:0] n);
        logic [SET_W:0] one_hot;
        int             k;
        k = (n > NUM_STATES) ? NUM_STATES : int'(n);
        one_hot = '0;
        one_hot[k] = 1'b1;
        return SET_W'(one_hot - 1'b1);
    endfunction

    function automatic logic [SET_W-1:0] moves_on(input logic [SET_W-1:0] from_set,
                                                  input logic [SYMBOL_BITS-1:0] sym,
                                                  input logic [SET_W-1:0] mask);
        logic [SET_W-1:0] nxt;
        nxt = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            if (from_set[s]) begin
                nxt |= trans_mem[{STATE_BITS'(s), sym}];
            end
        end
        return nxt & mask;
    endfunction

    // follow lambda moves until the set stops growing
    function automatic logic [SET_W-1:0] lambda_closure(input logic [SET_W-1:0] seed,
                                                        input logic [SET_W-1:0] mask);
        logic [SET_W-1:0] cur;
        logic [SET_W-1:0] prev;
        cur = seed & mask;
        do begin
            prev = cur;
            cur |= moves_on(cur, LAMBDA_SYM, mask);
        end while (cur != prev);
        return cur;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < TBL_DEPTH; a++) begin
                trans_mem[a] = '0;
            end
            act_set     = '0;
            init_state  = '0;
            accept_mask = '0;
            num_used    = CNT_W'(16);
            expected_sets.delete();
        end else begin
            if (o_valid) begin
                if (expected_sets.size() == 0) begin
                    report_mismatch("unexpected result, active_set", 32'(o_active_set), 32'h0);
                end else begin
                    want = expected_sets.pop_front();
                    if (o_active_set !== want.active_set) begin
                        report_mismatch("active_set", 32'(o_active_set), 32'(want.active_set));
                    end
                    if (o_accepted !== want.accepted) begin
                        report_mismatch("accepted", 32'(o_accepted), 32'(want.accepted));
                    end
                    if (o_dead !== want.dead) begin
                        report_mismatch("dead", 32'(o_dead), 32'(want.dead));
                    end
                end
            end

            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_INITIAL: init_state  = pwdata[STATE_BITS-1:0];
                    REG_FINAL:   accept_mask = pwdata[SET_W-1:0];
                    REG_COUNT:   num_used    = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (start && !busy) begin
                in_use = states_in_use(num_used);
                case (i_opcode)
                    OP_ADD_TRANS: begin
                        trans_mem[{i_from_state, i_symbol}] |= SET_W'(1) << i_to_state;
                    end
                    OP_START, OP_SYMBOL: begin
                        if (i_opcode == OP_START) begin
                            act_set = lambda_closure(SET_W'(1) << init_state, in_use);
                        end else begin
                            act_set = lambda_closure(moves_on(act_set & in_use, i_symbol,
                                                              in_use), in_use);
                        end
                        want.active_set = act_set;
                        want.accepted   = |(act_set & accept_mask);
                        want.dead       = (act_set == '0);
                        expected_sets.insert(expected_sets.size(), want);
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_sets.size();
    end

endmodule

// ===== verif/nfa_word_acceptor_top_tb.sv =====
// Testbench top for the NFA word acceptor: stimulus, register setup and verdict
`timescale 1ns / 1ps
module nfa_word_acceptor_top_tb;
    import nwa_pkg::*;

    localparam logic [1:0] OP_NONE    = 2'd3;   // unused opcode
    localparam logic [1:0] REG_SPARE  = 2'd3;   // unmapped register
    localparam int         ITEM_GOAL  = 1500;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             i_opcode;
    logic [STATE_BITS-1:0]  i_from_state;
    logic [SYMBOL_BITS-1:0] i_symbol;
    logic [STATE_BITS-1:0]  i_to_state;
    logic                   o_valid;
    logic [SET_W-1:0]       o_active_set;
    logic                   o_accepted;
    logic                   o_dead;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    int                     mismatches;
    int                     outstanding;
    int                     sent;
    bit                     steady;
    logic [SYMBOL_BITS-1:0] alpha [4];

    always #2 i_clk = ~i_clk;

    nfa_word_acceptor_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_from_state (i_from_state),
        .i_symbol     (i_symbol),
        .i_to_state   (i_to_state),
        .o_valid      (o_valid),
        .o_active_set (o_active_set),
        .o_accepted   (o_accepted),
        .o_dead       (o_dead),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    nfa_word_acceptor_checker CHECK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_from_state (i_from_state),
        .i_symbol     (i_symbol),
        .i_to_state   (i_to_state),
        .o_valid      (o_valid),
        .o_active_set (o_active_set),
        .o_accepted   (o_accepted),
        .o_dead       (o_dead),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_errors     (mismatches),
        .o_pending    (outstanding)
    );

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [SYMBOL_BITS-1:0] pick_symbol();
        int r;
        r = $urandom_range(99);
        if (r < 85) return alpha[$urandom_range(3)];
        if (r < 93) return LAMBDA_SYM;
        return SYMBOL_BITS'($urandom);
    endfunction

    // hold start until the block takes the item
    task automatic issue(input logic [1:0] op, input logic [STATE_BITS-1:0] from_s,
                         input logic [SYMBOL_BITS-1:0] sym, input logic [STATE_BITS-1:0] to_s);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_opcode     = op;
        i_from_state = from_s;
        i_symbol     = sym;
        i_to_state   = to_s;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (op != OP_NONE) sent++;
    endtask

    // wait until the block is idle and every result is in
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (busy !== 1'b0 || outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // upper bits are junk; the block keeps only the register width
    task automatic load_regs(input logic [3:0] init_s, input logic [15:0] fmask,
                             input logic [4:0] count);
        write_reg(REG_INITIAL, ($urandom & ~32'hF)    | 32'(init_s));
        write_reg(REG_FINAL,   ($urandom & ~32'hFFFF) | 32'(fmask));
        write_reg(REG_COUNT,   ($urandom & ~32'h1F)   | 32'(count));
    endtask

    task automatic run_word();
        int len;
        if ($urandom_range(9) != 0) begin
            issue(OP_START, 4'($urandom), 8'($urandom), 4'($urandom));
        end
        len = $urandom_range(6, 1);
        repeat (len) issue(OP_SYMBOL, 4'($urandom), pick_symbol(), 4'($urandom));
    endtask

    task automatic run_loads();
        int n;
        int r;
        logic [SYMBOL_BITS-1:0] sym;
        n = $urandom_range(3, 1);
        repeat (n) begin
            r = $urandom_range(99);
            // lambda moves kept rare so closures do not swallow every state
            if (r < 80) sym = alpha[$urandom_range(3)];
            else if (r < 85) sym = LAMBDA_SYM;
            else sym = SYMBOL_BITS'($urandom);
            issue(OP_ADD_TRANS, 4'($urandom), sym, 4'($urandom));
        end
    endtask

    initial begin
        int phase;
        int phase_end;
        int r;
        logic [4:0] count;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_opcode     = OP_ADD_TRANS;
        i_from_state = '0;
        i_symbol     = '0;
        i_to_state   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sent         = 0;
        steady       = 1'b0;
        for (int i = 0; i < 4; i++) alpha[i] = SYMBOL_BITS'("a" + i);
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // symbol before any start, start on an empty table, unused opcode
        issue(OP_SYMBOL, 4'd0, "a", 4'd0);
        issue(OP_START, 4'd0, 8'd0, 4'd0);
        issue(OP_NONE, 4'hF, 8'hFF, 4'hF);
        settle();
        load_regs(4'd0, 16'h8002, 5'd16);
        issue(OP_ADD_TRANS, 4'd0, "a", 4'd1);
        issue(OP_ADD_TRANS, 4'd1, LAMBDA_SYM, 4'd2);
        issue(OP_ADD_TRANS, 4'd2, "b", 4'd3);
        issue(OP_ADD_TRANS, 4'd3, LAMBDA_SYM, 4'd0);
        issue(OP_ADD_TRANS, 4'd0, "c", 4'd4);
        issue(OP_ADD_TRANS, 4'd4, LAMBDA_SYM, 4'd5);
        issue(OP_ADD_TRANS, 4'd5, LAMBDA_SYM, 4'd6);
        issue(OP_ADD_TRANS, 4'd6, LAMBDA_SYM, 4'd15);
        issue(OP_ADD_TRANS, 4'd15, 8'hFF, 4'd15);
        issue(OP_ADD_TRANS, 4'd15, 8'h00, 4'd14);
        issue(OP_ADD_TRANS, 4'd14, LAMBDA_SYM, 4'd4);
        issue(OP_START, 4'd0, 8'd0, 4'd0);
        issue(OP_SYMBOL, 4'd0, "a", 4'd0);
        issue(OP_SYMBOL, 4'd0, "b", 4'd0);
        issue(OP_SYMBOL, 4'd0, "c", 4'd0);
        issue(OP_SYMBOL, 4'd0, LAMBDA_SYM, 4'd0);    // lambda consumed as a symbol
        issue(OP_SYMBOL, 4'd0, 8'hFF, 4'd0);
        issue(OP_SYMBOL, 4'd0, 8'h00, 4'd0);
        issue(OP_START, 4'd0, 8'd0, 4'd0);
        issue(OP_SYMBOL, 4'd0, 8'h00, 4'd0);         // no move: set goes empty
        settle();
        load_regs(4'd12, 16'hFFFF, 5'd8);            // initial state out of use
        issue(OP_START, 4'd0, 8'd0, 4'd0);
        settle();
        load_regs(4'd0, 16'hFFFF, 5'd8);             // edges into unused states masked
        issue(OP_START, 4'd0, 8'd0, 4'd0);
        issue(OP_SYMBOL, 4'd0, "c", 4'd0);
        settle();
        write_reg(REG_SPARE, $urandom);
        load_regs(4'd0, 16'hFFFF, 5'd0);             // nothing in use
        issue(OP_START, 4'd0, 8'd0, 4'd0);
        settle();
        load_regs(4'd0, 16'h4000, 5'd31);            // count saturates
        issue(OP_START, 4'd0, 8'd0, 4'd0);
        issue(OP_SYMBOL, 4'd0, "c", 4'd0);

        phase = 0;
        while (sent < ITEM_GOAL) begin
            settle();
            r = $urandom_range(7);
            count = (r == 0) ? 5'($urandom) : 5'($urandom_range(16, 1));
            case (phase)
                0: load_regs(4'd0, 16'hFFFF, 5'd16);
                1: load_regs(4'd15, 16'h0000, 5'd1);
                2: load_regs(4'($urandom), 16'($urandom), 5'd0);
                3: load_regs(4'($urandom), 16'($urandom), 5'd31);
                default: load_regs(4'($urandom_range(count > 1 ? count - 1 : 0)),
                                   16'($urandom), count);
            endcase
            if (phase % 3 == 2) write_reg(REG_SPARE, $urandom);
            steady = ($urandom_range(3) == 0);
            for (int i = 0; i < 4; i++) alpha[i] = SYMBOL_BITS'($urandom);
            phase_end = sent + $urandom_range(250, 120);
            while (sent < phase_end && sent < ITEM_GOAL) begin
                r = $urandom_range(99);
                if (r < 20) run_loads();
                else if (r < 95) run_word();
                else if (r < 98) issue(OP_NONE, 4'($urandom), 8'($urandom), 4'($urandom));
                else issue(OP_SYMBOL, 4'($urandom), 8'($urandom), 4'($urandom));
                if ($urandom_range(59) == 0) settle();
            end
            phase++;
        end

        @(negedge i_clk);
        start = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/nwa_pkg.sv
src/nwa_ram.sv
src/nfa_word_acceptor_top.sv
src/nwa_chk.sv
verif/nfa_word_acceptor_checker.sv
verif/nfa_word_acceptor_top_tb.sv
